// ===== rtl/wsd_pkg.sv =====
// Shared types for the WebSocket frame deframer.
package wsd_pkg;

  localparam int unsigned LenW = 63;
  localparam logic [6:0] LenCode16 = 7'h7e;
  localparam logic [6:0] LenCode64 = 7'h7f;
  localparam logic [2:0] Len16Last = 3'd1;
  localparam logic [2:0] Len64Last = 3'd7;
  localparam logic [2:0] KeyLast   = 3'd3;

  typedef enum logic [5:0] {
    S_HDR0  = 6'b000001,
    S_HDR1  = 6'b000010,
    S_LEN16 = 6'b000100,
    S_LEN64 = 6'b001000,
    S_KEY   = 6'b010000,
    S_PAY   = 6'b100000
  } parse_state_e;

  typedef struct packed {
    logic            is_header;
    logic [7:0]      first_hdr;
    logic            mask;
    logic [LenW-1:0] len;
    logic [31:0]     key;
    logic [7:0]      data;
    logic            last;
  } entry_t;

endpackage

// ===== rtl/wsd_front.sv =====
// Header parser: walks each frame header and classifies every byte.
module wsd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  logic [7:0]      rx_byte_i,
  output logic            push_o,
  output wsd_pkg::entry_t entry_o
);

  wsd_pkg::parse_state_e state_q, state_d;
  logic [7:0]              fhdr_q, fhdr_d;
  logic                    mflag_q, mflag_d;
  logic [wsd_pkg::LenW-1:0] len_q, len_d;
  logic [wsd_pkg::LenW-1:0] rem_q, rem_d;
  logic [2:0]              cnt_q, cnt_d;
  logic [31:0]             key_q, key_d;
  logic                    hdr_end;
  logic                    emit_hdr;

  always_comb begin
    state_d  = state_q;
    fhdr_d   = fhdr_q;
    mflag_d  = mflag_q;
    len_d    = len_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    key_d    = key_q;
    hdr_end  = 1'b0;
    emit_hdr = 1'b0;
    push_o   = 1'b0;
    entry_o  = '0;
    if (acc_i) begin
      case (state_q)
        wsd_pkg::S_HDR1: begin
          mflag_d = rx_byte_i[7];
          cnt_d   = '0;
          key_d   = '0;
          len_d   = '0;
          if (rx_byte_i[6:0] == wsd_pkg::LenCode16) begin
            state_d = wsd_pkg::S_LEN16;
          end else if (rx_byte_i[6:0] == wsd_pkg::LenCode64) begin
            state_d = wsd_pkg::S_LEN64;
          end else begin
            len_d   = {{(wsd_pkg::LenW-7){1'b0}}, rx_byte_i[6:0]};
            hdr_end = 1'b1;
          end
        end
        wsd_pkg::S_LEN16, wsd_pkg::S_LEN64: begin
          len_d = {len_q[wsd_pkg::LenW-9:0], rx_byte_i};
          cnt_d = cnt_q + 3'd1;
          if ((state_q == wsd_pkg::S_LEN16 && cnt_q == wsd_pkg::Len16Last) ||
              (state_q == wsd_pkg::S_LEN64 && cnt_q == wsd_pkg::Len64Last)) begin
            hdr_end = 1'b1;
          end
        end
        wsd_pkg::S_KEY: begin
          key_d = {key_q[23:0], rx_byte_i};
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == wsd_pkg::KeyLast) begin
            emit_hdr = 1'b1;
          end
        end
        wsd_pkg::S_PAY: begin
          rem_d           = rem_q - {{(wsd_pkg::LenW-1){1'b0}}, 1'b1};
          push_o          = 1'b1;
          entry_o.data    = rx_byte_i;
          entry_o.last    = (rem_d == '0);
          if (rem_d == '0) begin
            state_d = wsd_pkg::S_HDR0;
          end
        end
        default: begin
          fhdr_d  = rx_byte_i;
          state_d = wsd_pkg::S_HDR1;
        end
      endcase

      if (hdr_end) begin
        if (mflag_d) begin
          cnt_d   = '0;
          state_d = wsd_pkg::S_KEY;
        end else begin
          emit_hdr = 1'b1;
        end
      end

      if (emit_hdr) begin
        cnt_d             = '0;
        rem_d             = len_d;
        state_d           = (len_d == '0) ? wsd_pkg::S_HDR0 : wsd_pkg::S_PAY;
        push_o            = 1'b1;
        entry_o.is_header = 1'b1;
        entry_o.first_hdr = fhdr_d;
        entry_o.mask      = mflag_d;
        entry_o.len       = len_d;
        entry_o.key       = key_d;
        entry_o.last      = (len_d == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wsd_pkg::S_HDR0;
      cnt_q   <= '0;
      mflag_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mflag_q <= mflag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fhdr_q <= fhdr_d;
    len_q  <= len_d;
    rem_q  <= rem_d;
    key_q  <= key_d;
  end

  a_rem_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wsd_pkg::S_PAY |-> rem_q != '0)
    else $error("payload phase with no bytes left");

  a_push_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> acc_i)
    else $error("request queued without an accepted byte");

endmodule

// ===== rtl/wsd_queue.sv =====
// Short request queue between the parser and the output stage.
module wsd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wsd_pkg::entry_t wdata_i,
  input  logic            pop_i,
  output wsd_pkg::entry_t rdata_o,
  output logic            valid_o,
  output logic            full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntMax = CntW'(DEPTH);

  wsd_pkg::entry_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntMax);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrMax) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrMax) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("queue count beyond depth");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("request pushed into a full queue");

endmodule

// ===== rtl/wsd_back.sv =====
// Output stage: unmasks payload bytes and holds the result register.
module wsd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  wsd_pkg::entry_t           q_data_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      is_header_o,
  output logic                      fin_bit_o,
  output logic                      rsv_one_o,
  output logic                      rsv_two_o,
  output logic                      rsv_three_o,
  output logic [3:0]                frame_opcode_o,
  output logic                      masked_o,
  output logic [wsd_pkg::LenW-1:0]  payload_length_o,
  output logic [7:0]                data_byte_o,
  output logic                      last_o
);

  logic                     valid_q, valid_d;
  logic                     load;
  logic                     mflag_q;
  logic [31:0]              key_q;
  logic [1:0]               idx_q;
  logic [7:0]               key_byte;
  logic                     hdr_q;
  logic [7:0]               fhdr_q;
  logic                     msk_q;
  logic [wsd_pkg::LenW-1:0] len_q;
  logic [7:0]               data_q;
  logic                     last_q;

  assign load  = !valid_q || !out_stall_i;
  assign pop_o = load && q_valid_i;

  always_comb begin
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
    if (!mflag_q) begin
      key_byte = '0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = q_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
      mflag_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (pop_o) begin
        if (q_data_i.is_header) begin
          idx_q   <= '0;
          mflag_q <= q_data_i.mask;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      hdr_q  <= q_data_i.is_header;
      last_q <= q_data_i.last;
      if (q_data_i.is_header) begin
        key_q  <= q_data_i.key;
        fhdr_q <= q_data_i.first_hdr;
        msk_q  <= q_data_i.mask;
        len_q  <= q_data_i.len;
        data_q <= '0;
      end else begin
        fhdr_q <= '0;
        msk_q  <= 1'b0;
        len_q  <= '0;
        data_q <= q_data_i.data ^ key_byte;
      end
    end
  end

  assign out_valid_o      = valid_q;
  assign is_header_o      = hdr_q;
  assign fin_bit_o        = fhdr_q[7];
  assign rsv_one_o        = fhdr_q[6];
  assign rsv_two_o        = fhdr_q[5];
  assign rsv_three_o      = fhdr_q[4];
  assign frame_opcode_o   = fhdr_q[3:0];
  assign masked_o         = msk_q;
  assign payload_length_o = len_q;
  assign data_byte_o      = data_q;
  assign last_o           = last_q;

  a_idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && q_data_i.is_header |=> idx_q == '0)
    else $error("key index not restarted on a new header");

endmodule

// ===== rtl/websocket_frame_deframer.sv =====
// WebSocket frame deframer top level.
// Takes one received byte per cycle and parses RFC 6455 frames: two header
// bytes, an optional 16-bit or 64-bit big-endian length (low 63 bits kept) and
// an optional 4-byte mask key. The byte that completes a header yields one
// header result (last set when the payload is empty); every payload byte
// yields one unmasked data result, the final one flagged last. Other header
// bytes yield nothing. With QUEUE_DEPTH above one, the sustained rate is one
// byte per cycle while the output is not stalled; each result is held in the
// queue entry and then in the output register. The input stalls only when the
// QUEUE_DEPTH-entry queue behind the parser fills while the output is stalled.
module websocket_frame_deframer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      is_header_o,
  output logic                      fin_bit_o,
  output logic                      rsv_one_o,
  output logic                      rsv_two_o,
  output logic                      rsv_three_o,
  output logic [3:0]                frame_opcode_o,
  output logic                      masked_o,
  output logic [wsd_pkg::LenW-1:0]  payload_length_o,
  output logic [7:0]                data_byte_o,
  output logic                      last_o
);

  logic            acc;
  logic            push;
  logic            pop;
  logic            q_valid;
  logic            q_full;
  wsd_pkg::entry_t push_entry;
  wsd_pkg::entry_t head_entry;

  assign in_stall_o = q_full;
  assign acc        = in_valid_i && !q_full;

  wsd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (head_entry),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  wsd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_data_i         (head_entry),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .is_header_o      (is_header_o),
    .fin_bit_o        (fin_bit_o),
    .rsv_one_o        (rsv_one_o),
    .rsv_two_o        (rsv_two_o),
    .rsv_three_o      (rsv_three_o),
    .frame_opcode_o   (frame_opcode_o),
    .masked_o         (masked_o),
    .payload_length_o (payload_length_o),
    .data_byte_o      (data_byte_o),
    .last_o           (last_o)
  );

endmodule
